// File: hdl/modular_exponentiation_assert.svh
// Assertion shorthands used by the modular exponentiation top level.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication.
`define MEXP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mexp check failed");

// Next-cycle implication.
`define MEXP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mexp check failed");

`endif

// File: hdl/mexp_pkg.sv
package mexp_pkg;

	localparam int OP_W  = 63;
	localparam int MOD_W = 31;
	localparam int CNT_W = 6;

	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	// Bit counts loaded into the serial unit.
	localparam logic [CNT_W-1:0] NBITS_OP  = 6'd63;
	localparam logic [CNT_W-1:0] NBITS_MOD = 6'd31;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
	} mexp_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mexp_sts_t;

endpackage

// File: hdl/modular_exponentiation.sv
// Channel   Dir  Width  Contents (lowest bit first)
// s_*       in   128    tdata: base[62:0], exponent[125:63], zero fill
// m_*       out  32     tdata: power[30:0], zero fill
// cfg_*     in   31     modulus, written when cfg_wen is high
//
// One word at a time. Reducing the base runs 63 serial steps and a done pulse. Each
// exponent bit up to the highest one set then runs a load state, 31 serial steps and a
// done pulse; result-times-base and base-squared run in two serial units side by side.
// Reset sets the modulus to 1000000007. A waiting result stalls only the next word's
// final state, not its acceptance.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int EXPONENT_BITS = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // base[62:0], exponent[125:63]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // power[30:0]
	input  logic         cfg_wen,
	input  logic [30:0]  cfg_wdata
);

	`include "modular_exponentiation_assert.svh"

	localparam int PAD_W = OP_W - MOD_W;

	state_t                   state_q;
	logic [MOD_W-1:0]         mod_q;
	logic [MOD_W-1:0]         m_eff;
	logic [EXPONENT_BITS-1:0] k_q;
	logic [MOD_W-1:0]         x_q;
	logic [MOD_W-1:0]         res_q;
	logic [MOD_W-1:0]         out_q;
	logic                     out_valid_q;

	mexp_cmd_t        xcmd;
	mexp_cmd_t        rcmd;
	mexp_sts_t        xsts;
	mexp_sts_t        rsts;
	logic [MOD_W-1:0] xa;
	logic [OP_W-1:0]  xb;
	logic [MOD_W-1:0] xr;
	logic [MOD_W-1:0] rr;
	logic             accept;
	logic             k_more;
	logic             out_load;

	assign m_eff    = (mod_q == '0) ? MOD_W'(1) : mod_q;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign k_more   = ((k_q >> 1) != '0);
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	always_comb begin
		xcmd.start = 1'b0;
		xcmd.nbits = NBITS_MOD;
		// The multiplicand is read on every serial step, so it stays one for the
		// whole reduction.
		xa         = (state_q == ST_RED) ? MOD_W'(1) : x_q;
		xb         = {x_q, {PAD_W{1'b0}}};
		if (accept) begin
			// Reducing the base is a multiply by one with the base as multiplier.
			xcmd.start = 1'b1;
			xcmd.nbits = NBITS_OP;
			xa         = MOD_W'(1);
			xb         = s_tdata[OP_W-1:0];
		end else if (state_q == ST_LOAD) begin
			xcmd.start = 1'b1;
		end
		rcmd.start = (state_q == ST_LOAD);
		rcmd.nbits = NBITS_MOD;
	end

	mexp_mulmod u_xunit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (xcmd),
		.a      (xa),
		.b      (xb),
		.m      (m_eff),
		.sts    (xsts),
		.r      (xr)
	);

	mexp_mulmod u_runit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rcmd),
		.a      (x_q),
		.b      ({res_q, {PAD_W{1'b0}}}),
		.m      (m_eff),
		.sts    (rsts),
		.r      (rr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (cfg_wen) begin
			mod_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (xsts.done) begin
						state_q <= (k_q == '0) ? ST_FIN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (xsts.done) begin
						state_q <= k_more ? ST_LOAD : ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			k_q   <= s_tdata[OP_W +: EXPONENT_BITS];
			res_q <= MOD_W'(1);
		end
		if ((state_q == ST_RED) && xsts.done) begin
			x_q <= xr;
		end
		if ((state_q == ST_MUL) && xsts.done) begin
			x_q <= xr;
			k_q <= k_q >> 1;
			if (k_q[0]) begin
				res_q <= rr;
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	`MEXP_ASSERT_NXT(a_accept_starts, accept, (state_q == ST_RED) && xsts.busy)
	`MEXP_ASSERT_IMP(a_units_in_step, xsts.busy || rsts.busy,
		(state_q == ST_RED) || (state_q == ST_MUL))
	`MEXP_ASSERT_IMP(a_xunit_reduced, xsts.done, xr < m_eff)
	`MEXP_ASSERT_IMP(a_units_lockstep, state_q == ST_MUL, xsts.done == rsts.done)

endmodule

// File: hdl/mexp_mulmod.sv
// Bit-serial modular multiply: r = (a * b) mod m, scanning b from its top bit.
// Each busy cycle r becomes (2r + bit*a) mod m. With r < m and a < m the sum stays
// below 3m, so one of two parallel subtractions brings it back into range.
module mexp_mulmod
	import mexp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mexp_cmd_t        cmd,
	input  logic [MOD_W-1:0] a,
	input  logic [OP_W-1:0]  b,
	input  logic [MOD_W-1:0] m,
	output mexp_sts_t        sts,
	output logic [MOD_W-1:0] r
);

	logic [MOD_W-1:0] r_q;
	logic [OP_W-1:0]  b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [MOD_W+1:0] v;
	logic [MOD_W+2:0] t1;
	logic [MOD_W+2:0] t2;
	logic [MOD_W-1:0] r_next;

	always_comb begin
		v  = {1'b0, r_q, 1'b0} + (b_q[OP_W-1] ? {2'b00, a} : '0);
		t1 = {1'b0, v} - {3'b000, m};
		t2 = {1'b0, v} - {2'b00, m, 1'b0};
		priority if (!t2[MOD_W+2]) begin
			r_next = t2[MOD_W-1:0];
		end else if (!t1[MOD_W+2]) begin
			r_next = t1[MOD_W-1:0];
		end else begin
			r_next = v[MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			r_q <= '0;
			b_q <= b;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[OP_W-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign r        = r_q;

endmodule

// File: dv/tb_top.sv
module tb_top;
	import mexp_pkg::*;

	typedef bit [OP_W-1:0]  operand_t;
	typedef bit [MOD_W-1:0] residue_t;

	localparam operand_t OPERAND_MAX      = '1;
	localparam residue_t MOD_MAX          = '1;
	localparam operand_t EXP_TOP_BIT      = operand_t'(1) << (OP_W - 1);
	localparam int       FULL_HOLD_CYCLES = 9000;
	localparam int       DRAIN_CYCLES     = 2200;
	localparam int       REPORT_LIMIT     = 10;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;    // base[62:0], exponent[125:63]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;         // power[30:0]
	logic         cfg_wen = 1'b0;
	logic [30:0]  cfg_wdata = '0;

	residue_t modulus_reg = MOD_RESET;
	residue_t power_queue[$];
	int       fail_count = 0;
	bit       idling_on = 1'b1;
	int       hold_left = 0;

	modular_exponentiation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Right-to-left square-and-multiply. A zero modulus behaves as one, and a zero
	// exponent leaves the accumulator at one without any reduction.
	function automatic residue_t predict_power(operand_t base, operand_t exponent,
			residue_t modulus);
		bit [63:0] m;
		bit [63:0] x;
		bit [63:0] acc;
		operand_t  k;
		m = (modulus == '0) ? 64'd1 : 64'(modulus);
		x = 64'(base) % m;
		acc = 64'd1;
		k = exponent;
		while (k != '0) begin
			if (k[0]) begin
				acc = (acc * x) % m;
			end
			x = (x * x) % m;
			k = k >> 1;
		end
		return residue_t'(acc);
	endfunction

	function automatic operand_t rand_operand();
		return operand_t'({$urandom, $urandom});
	endfunction

	function automatic operand_t rand_base();
		operand_t b;
		case ($urandom_range(0, 5))
			0: begin
				b = operand_t'($urandom_range(0, 3));
			end
			1: begin
				b = OPERAND_MAX - operand_t'($urandom_range(0, 3));
			end
			2: begin
				// Near a multiple of the modulus, so the reduction lands on small values.
				b = operand_t'(modulus_reg) * operand_t'($urandom_range(1, 1 << 20))
					+ operand_t'($urandom_range(0, 2));
			end
			3: begin
				b = operand_t'($urandom);
			end
			default: begin
				b = rand_operand();
			end
		endcase
		return b;
	endfunction

	function automatic operand_t rand_exponent();
		operand_t e;
		case ($urandom_range(0, 4))
			0: begin
				e = operand_t'($urandom_range(0, 3));
			end
			1: begin
				e = rand_operand() >> $urandom_range(1, OP_W - 1);
			end
			2: begin
				e = OPERAND_MAX;
			end
			default: begin
				e = rand_operand();
			end
		endcase
		return e;
	endfunction

	// Called right after a rising edge; returns right after the edge that took the word.
	task automatic send_word(input operand_t base, input operand_t exponent);
		int gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, exponent, base};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		power_queue.push_back(predict_power(base, exponent, modulus_reg));
	endtask

	// Every word yields exactly one result, so an empty queue means the block is idle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (power_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_modulus(input residue_t value);
		wait_idle();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		modulus_reg = value;
	endtask

	task automatic test_reset_modulus();
		send_word('0, '0);
		send_word('0, operand_t'(1));
		send_word('0, OPERAND_MAX);
		send_word(OPERAND_MAX, '0);
		send_word(OPERAND_MAX, OPERAND_MAX);
		send_word(operand_t'(1), OPERAND_MAX);
		send_word(operand_t'(MOD_RESET), operand_t'(5));
		send_word(operand_t'(MOD_RESET) - operand_t'(1), operand_t'(2));
		send_word(operand_t'(2), EXP_TOP_BIT);
		send_word(operand_t'({32{2'b10}}), operand_t'({32{2'b01}}));
	endtask

	task automatic test_modulus_extremes();
		write_modulus(residue_t'(1));
		send_word(operand_t'(5), '0);
		send_word(OPERAND_MAX, OPERAND_MAX);
		// An out-of-range zero modulus must act like a modulus of one.
		write_modulus('0);
		send_word(operand_t'(7), '0);
		send_word(operand_t'(7), operand_t'(3));
		write_modulus(MOD_MAX);
		send_word(operand_t'(MOD_MAX) - operand_t'(1), OPERAND_MAX);
		send_word(OPERAND_MAX, operand_t'(2));
		send_word(operand_t'(MOD_MAX), operand_t'(1));
		write_modulus(residue_t'(2));
		send_word(operand_t'(3), operand_t'({32{2'b01}}));
	endtask

	task automatic test_random_moduli();
		residue_t mod_plan[5];
		mod_plan = '{residue_t'(3), residue_t'(65536), residue_t'($urandom), MOD_RESET,
			residue_t'($urandom_range(2, 1000))};
		foreach (mod_plan[i]) begin
			write_modulus(mod_plan[i]);
			repeat (20) send_word(rand_base(), rand_exponent());
		end
	endtask

	// Long exponents with the output held off, so a finished result sits waiting
	// while the next one completes and the input has to stall.
	task automatic test_output_backpressure();
		write_modulus(MOD_MAX - residue_t'($urandom_range(0, 1000)));
		hold_left = FULL_HOLD_CYCLES;
		repeat (5) send_word(rand_base(), rand_operand() | EXP_TOP_BIT);
	endtask

	task automatic test_no_idle();
		idling_on = 1'b0;
		write_modulus(residue_t'($urandom));
		repeat (30) send_word(rand_base(), rand_exponent());
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_power
		residue_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (power_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT) begin
					$display("%0t: result word %0d with nothing pending", $time,
						m_tdata[30:0]);
				end
			end else begin
				want = power_queue.pop_front();
				if (m_tdata[30:0] !== want) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("%0t: power mismatch: expected %0d, got %0d", $time, want,
							m_tdata[30:0]);
					end
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_modulus();
		test_modulus_extremes();
		test_random_moduli();
		test_output_backpressure();
		test_no_idle();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#25000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
